[sv/double_ended_queue_unit_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication.
`define DQU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define DQU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/dq_pkg.sv]
package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic shift_r;
    logic shift_l;
    logic push_back;
    logic pop_back;
  } cell_cmd_t;

endpackage

[sv/dq_if.sv]
interface dq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic [4:0]         occupancy;

  modport source (output valid, output result_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input result_value, input status, input occupancy,
                  output ready);
endinterface

[sv/dq_cell.sv]
module dq_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dq_pkg::cell_cmd_t                   cmd_i,
  input  logic signed [dq_pkg::DATA_W-1:0]    push_val_i,
  input  logic signed [dq_pkg::DATA_W-1:0]    left_data_i,
  input  logic                                left_occ_i,
  input  logic signed [dq_pkg::DATA_W-1:0]    right_data_i,
  input  logic                                right_occ_i,
  output logic signed [dq_pkg::DATA_W-1:0]    data_o,
  output logic                                occ_o,
  output logic                                last_o
);
  import dq_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     occ_q, occ_d;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    if (cmd_i.shift_r) begin
      data_d = left_data_i;
      occ_d  = left_occ_i;
    end else if (cmd_i.shift_l) begin
      data_d = right_data_i;
      occ_d  = right_occ_i;
    end else if (cmd_i.push_back && !occ_q && left_occ_i) begin
      data_d = push_val_i;
      occ_d  = 1'b1;
    end else if (cmd_i.pop_back && occ_q && !right_occ_i) begin
      occ_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign occ_o  = occ_q;
  assign last_o = occ_q & ~right_occ_i;

endmodule

[sv/double_ended_queue_unit.sv]
// Double-ended queue of signed 32-bit values, held in a row of cells.
// req_i carries one operation per transaction (mode, value): push front,
// push back, pop front, pop back, peek front or peek back. rsp_o returns
// exactly one transaction per request with the value read, a status
// (ok, empty, full) and the occupancy after the operation.
// The front entry always sits in cell 0; push front and pop front shift
// the whole row by one cell, all cells together, while push back and pop
// back touch only the cell at the tail boundary.
// Response: registered, valid in the cycle after the request is taken.
// Throughput: one request per cycle while no response waits on a low
// rsp_o.ready, set by the registered cell update and the one-entry response register.
// Stall: while a response waits and rsp_o.ready is low, req_i.ready is
// low; when the response is taken a new request is accepted in the same
// cycle.
// Reset: the queue is empty and no response is pending; stored data is
// not cleared and no clearing sweep runs, so requests are taken at once.
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);
  import dq_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rsp_valid_q;
  logic signed [DATA_W-1:0] res_q, res_d;
  status_e          status_q, status_d;
  logic [OCC_W-1:0] occ_out_q;

  cell_cmd_t        cmd;
  logic             in_ready, in_fire, full, empty;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_occ;
  logic [DEPTH-1:0]         cell_last;
  logic signed [DATA_W-1:0] back_data;

  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign in_ready = ~rsp_valid_q | rsp_o.ready;
  assign in_fire  = req_i.valid & in_ready;

  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | (cell_last[i] ? cell_data[i] : '0);
    end
  end

  always_comb begin
    cmd      = '0;
    cnt_d    = cnt_q;
    res_d    = '0;
    status_d = STAT_OK;
    case (mode_e'(req_i.mode))
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          cmd.shift_r   = (mode_e'(req_i.mode) == MODE_PUSH_FRONT);
          cmd.push_back = (mode_e'(req_i.mode) == MODE_PUSH_BACK);
          cnt_d         = cnt_q + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          res_d = cell_data[0];
          if (mode_e'(req_i.mode) == MODE_POP_FRONT) begin
            cmd.shift_l = 1'b1;
            cnt_d       = cnt_q - 1'b1;
          end
        end
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          res_d = back_data;
          if (mode_e'(req_i.mode) == MODE_POP_BACK) begin
            cmd.pop_back = 1'b1;
            cnt_d        = cnt_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (!in_fire) begin
      cmd   = '0;
      cnt_d = cnt_q;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .push_val_i   (req_i.value),
      .left_data_i  ((i == 0) ? req_i.value : cell_data[(i == 0) ? 0 : i - 1]),
      .left_occ_i   ((i == 0) ? 1'b1 : cell_occ[(i == 0) ? 0 : i - 1]),
      .right_data_i ((i == DEPTH - 1) ? '0 : cell_data[(i == DEPTH - 1) ? i : i + 1]),
      .right_occ_i  ((i == DEPTH - 1) ? 1'b0 : cell_occ[(i == DEPTH - 1) ? i : i + 1]),
      .data_o       (cell_data[i]),
      .occ_o        (cell_occ[i]),
      .last_o       (cell_last[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q     <= res_d;
      status_q  <= status_d;
      occ_out_q <= OCC_W'(cnt_d);
    end
  end

  assign req_i.ready        = in_ready;
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.result_value = res_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.occupancy    = occ_out_q;

  `DQU_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(DEPTH))
  `DQU_ASSERT_IMP(a_occ_matches_cnt, clk_i, rst_ni, 1'b1,
                  CNT_W'($countones(cell_occ)) == cnt_q)
  `DQU_ASSERT_IMP(a_occ_contiguous, clk_i, rst_ni, 1'b1,
                  (cell_occ & (cell_occ + 1'b1)) == '0)
  `DQU_ASSERT_IMP(a_one_tail, clk_i, rst_ni, !empty, $onehot(cell_last))
  `DQU_ASSERT_NXT(a_push_grows, clk_i, rst_ni,
                  in_fire && !full && (req_i.mode == MODE_PUSH_FRONT ||
                  req_i.mode == MODE_PUSH_BACK),
                  cnt_q == $past(cnt_q) + 1'b1)

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import dq_pkg::*;

  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam int HOLD_CYCLES = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int IDX_W = $clog2(DEPTH);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } deq_rsp_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic [4:0]               reps;
    logic                     pinned;
    deq_rsp_t                 rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dq_req_if req_if ();
  dq_rsp_if rsp_if ();

  double_ended_queue_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow ring of the deque.
  logic signed [DATA_W-1:0] ring_q [DEPTH];
  logic [IDX_W-1:0]         head_q = '0;
  logic [CNT_W-1:0]         fill_q = '0;

  deq_rsp_t due_rsps [$];
  deq_rsp_t pred_rsp;
  deq_rsp_t got_rsp;
  logic     drv_pinned = 1'b0;
  deq_rsp_t drv_pin = '0;
  int       err_count = 0;
  int       quiet_cycles = 0;
  int       src_idle_pct = 37;
  int       snk_idle_pct = 82;
  int       hold_asked = 0;
  int       hold_taken = 0;
  int       hold_left = 0;

  // Directed rows: pinned rows carry the expected transaction, the rest use the shadow ring.
  dir_row_t dir_rows [25] = '{
    '{MODE_POP_FRONT,  32'sh0,        5'd1,  1'b1, '{32'sh0, STAT_EMPTY, 5'd0}},
    '{MODE_POP_BACK,   -32'sd1,       5'd1,  1'b1, '{32'sh0, STAT_EMPTY, 5'd0}},
    '{MODE_PEEK_FRONT, 32'sh0,        5'd1,  1'b1, '{32'sh0, STAT_EMPTY, 5'd0}},
    '{MODE_PEEK_BACK,  32'sh0,        5'd1,  1'b1, '{32'sh0, STAT_EMPTY, 5'd0}},
    '{MODE_RSVD6,      32'sh12345678, 5'd1,  1'b1, '{32'sh0, STAT_OK, 5'd0}},
    '{MODE_PUSH_BACK,  32'sh7FFFFFFF, 5'd1,  1'b1, '{32'sh0, STAT_OK, 5'd1}},
    '{MODE_PEEK_BACK,  32'sh0,        5'd1,  1'b1, '{32'sh7FFFFFFF, STAT_OK, 5'd1}},
    '{MODE_PUSH_FRONT, 32'sh80000000, 5'd1,  1'b1, '{32'sh0, STAT_OK, 5'd2}},
    '{MODE_PEEK_FRONT, 32'sh0,        5'd1,  1'b1, '{32'sh80000000, STAT_OK, 5'd2}},
    '{MODE_PEEK_BACK,  32'sh0,        5'd1,  1'b0, '0},
    '{MODE_POP_BACK,   32'sh0,        5'd1,  1'b1, '{32'sh7FFFFFFF, STAT_OK, 5'd1}},
    '{MODE_PEEK_BACK,  32'sh0,        5'd1,  1'b1, '{32'sh80000000, STAT_OK, 5'd1}},
    '{MODE_PUSH_BACK,  -32'sd1,       5'd1,  1'b0, '0},
    '{MODE_PUSH_FRONT, 32'sh0,        5'd1,  1'b0, '0},
    '{MODE_POP_FRONT,  32'sh0,        5'd1,  1'b0, '0},
    '{MODE_POP_FRONT,  32'sh0,        5'd1,  1'b0, '0},
    '{MODE_POP_FRONT,  32'sh0,        5'd1,  1'b0, '0},
    '{MODE_POP_BACK,   32'sh0,        5'd1,  1'b1, '{32'sh0, STAT_EMPTY, 5'd0}},
    '{MODE_PUSH_FRONT, 32'sh13579BDF, 5'd16, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'sh55555555, 5'd1,  1'b1, '{32'sh0, STAT_FULL, 5'd16}},
    '{MODE_PUSH_BACK,  32'shAAAAAAAA, 5'd1,  1'b1, '{32'sh0, STAT_FULL, 5'd16}},
    '{MODE_RSVD7,      32'sh0,        5'd1,  1'b1, '{32'sh0, STAT_OK, 5'd16}},
    '{MODE_PEEK_BACK,  32'sh0,        5'd1,  1'b0, '0},
    '{MODE_POP_BACK,   32'sh0,        5'd8,  1'b0, '0},
    '{MODE_PUSH_BACK,  32'sh2468ACE0, 5'd8,  1'b0, '0}
  };

  function automatic deq_rsp_t deq_apply(input logic [2:0] m, input logic signed [31:0] v);
    deq_rsp_t r;
    logic [IDX_W-1:0] slot;
    r = '0;
    case (m)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (fill_q == DEPTH) begin
          r.status = STAT_FULL;
        end else if (m == MODE_PUSH_FRONT) begin
          head_q = IDX_W'((head_q + DEPTH - 1) % DEPTH);
          ring_q[head_q] = v;
          fill_q = fill_q + 1'b1;
        end else begin
          ring_q[IDX_W'((head_q + fill_q) % DEPTH)] = v;
          fill_q = fill_q + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        if (fill_q == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          if (m == MODE_POP_FRONT || m == MODE_PEEK_FRONT) begin
            slot = head_q;
          end else begin
            slot = IDX_W'((head_q + fill_q - 1) % DEPTH);
          end
          r.value = ring_q[slot];
          if (m == MODE_POP_FRONT) begin
            head_q = IDX_W'((head_q + 1) % DEPTH);
            fill_q = fill_q - 1'b1;
          end else if (m == MODE_POP_BACK) begin
            fill_q = fill_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = fill_q;
    return r;
  endfunction

  task automatic check_rsp(input deq_rsp_t exp, input deq_rsp_t act);
    if (act.value !== exp.value) begin
      $display("%0t ns: result_value expected %h got %h", $time, exp.value, act.value);
      err_count++;
    end
    if (act.status !== exp.status) begin
      $display("%0t ns: status expected %0d got %0d", $time, exp.status, act.status);
      err_count++;
    end
    if (act.occupancy !== exp.occupancy) begin
      $display("%0t ns: occupancy expected %0d got %0d", $time, exp.occupancy, act.occupancy);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        pred_rsp = deq_apply(req_if.mode, req_if.value);
        due_rsps.push_back(drv_pinned ? drv_pin : pred_rsp);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got_rsp = {rsp_if.result_value, rsp_if.status, rsp_if.occupancy};
        if (due_rsps.size() == 0) begin
          $display("%0t ns: unexpected transaction, expected none got %h/%0d/%0d", $time,
                   got_rsp.value, got_rsp.status, got_rsp.occupancy);
          err_count++;
        end else begin
          check_rsp(due_rsps.pop_front(), got_rsp);
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
  end

  // Response side: random back-pressure plus one long hold, asked for by the stimulus.
  always @(negedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    wait (rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL double_ended_queue_unit");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(input logic [2:0] m, input logic signed [31:0] v, input logic pin_on,
                         input deq_rsp_t pin);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    drv_pinned = pin_on;
    drv_pin = pin;
    req_if.valid <= 1'b1;
    req_if.mode <= m;
    req_if.value <= v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_rsps();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (due_rsps.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(input int n_items);
    int push_pct;
    int seg_left;
    logic [2:0] m;
    logic signed [31:0] v;
    push_pct = 50;
    seg_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        case ($urandom_range(2))
          0: push_pct = 75;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
        seg_left = $urandom_range(8, 40);
      end
      seg_left--;
      if ($urandom_range(99) < 3) begin
        m = $urandom_range(1) ? MODE_RSVD7 : MODE_RSVD6;
      end else if ($urandom_range(99) < push_pct) begin
        m = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
      end else begin
        case ($urandom_range(3))
          0: m = MODE_POP_FRONT;
          1: m = MODE_POP_BACK;
          2: m = MODE_PEEK_FRONT;
          default: m = MODE_PEEK_BACK;
        endcase
      end
      case ($urandom_range(7))
        0: v = 32'sh7FFFFFFF;
        1: v = 32'sh80000000;
        2: v = 32'sh0;
        3: v = -32'sd1;
        default: v = $urandom;
      endcase
      send_op(m, v, 1'b0, '0);
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.mode = MODE_PUSH_FRONT;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < 25; r++) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        send_op(dir_rows[r].mode, dir_rows[r].value + k, dir_rows[r].pinned, dir_rows[r].rsp);
      end
    end
    run_random(450);
    drain_rsps();

    src_idle_pct = 82;
    snk_idle_pct = 37;
    run_random(450);
    drain_rsps();

    // Long response hold while requests keep coming.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_asked = hold_asked + 1;
    run_random(40);
    run_random(450);
    drain_rsps();

    repeat (4) @(negedge clk);
    if (err_count == 0) begin
      $display("PASS double_ended_queue_unit");
    end else begin
      $display("FAIL double_ended_queue_unit");
    end
    $finish;
  end

endmodule
